[rtl/ecs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ecs_pkg;

   localparam int FRAC_BITS = 16;
   localparam int TW = FRAC_BITS + 1;
   localparam int VW = 24;
   localparam int PW = 2 * VW;
   localparam int IW = 12;
   localparam int CW = 13;

   localparam logic [4:0] SH_F    = 5'(FRAC_BITS);
   localparam logic [4:0] SH_BNC  = 5'(FRAC_BITS + 4);
   localparam logic [4:0] SH_BNC3 = 5'(FRAC_BITS + 6);
   localparam logic [4:0] SH_HALF = 5'd1;

   localparam logic signed [VW-1:0] ONE_V   = VW'(64'sd1 <<< FRAC_BITS);
   localparam logic signed [VW-1:0] TWO_V   = VW'(64'sd2 <<< FRAC_BITS);
   localparam logic signed [VW-1:0] SIX_V   = VW'(64'sd6 <<< FRAC_BITS);
   localparam logic signed [VW-1:0] NINE_V  = VW'(64'sd9 <<< FRAC_BITS);
   localparam logic signed [VW-1:0] TW1_V   = VW'(64'sd21 <<< FRAC_BITS);
   localparam logic signed [VW-1:0] BC1_V   = VW'((64'sd3 <<< FRAC_BITS) / 4);
   localparam logic signed [VW-1:0] BC2_V   = VW'((64'sd15 <<< FRAC_BITS) / 16);
   localparam logic signed [VW-1:0] BC3_V   = VW'((64'sd63 <<< FRAC_BITS) / 64);
   // bounce breakpoints on t: 11*t < k*ONE  <=>  t < ceil(k*ONE/11)
   localparam logic signed [VW-1:0] BT1_V   = VW'(((64'sd4 <<< FRAC_BITS) + 10) / 11);
   localparam logic signed [VW-1:0] BT2_V   = VW'(((64'sd8 <<< FRAC_BITS) + 10) / 11);
   localparam logic signed [VW-1:0] BT3_V   = VW'(((64'sd10 <<< FRAC_BITS) + 10) / 11);

   localparam logic [3:0] MODE_QUAD_IN     = 4'd1;
   localparam logic [3:0] MODE_QUAD_OUT    = 4'd2;
   localparam logic [3:0] MODE_QUAD_INOUT  = 4'd3;
   localparam logic [3:0] MODE_CUBE_IN     = 4'd4;
   localparam logic [3:0] MODE_CUBE_OUT    = 4'd5;
   localparam logic [3:0] MODE_CUBE_INOUT  = 4'd6;
   localparam logic [3:0] MODE_BACK_IN     = 4'd7;
   localparam logic [3:0] MODE_BACK_OUT    = 4'd8;
   localparam logic [3:0] MODE_BACK_INOUT  = 4'd9;
   localparam logic [3:0] MODE_BNC_IN      = 4'd10;
   localparam logic [3:0] MODE_BNC_OUT     = 4'd11;
   localparam logic [3:0] MODE_BNC_INOUT   = 4'd12;

   localparam logic [2:0] OP_LIN  = 3'd0;
   localparam logic [2:0] OP_SQ   = 3'd1;
   localparam logic [2:0] OP_QO   = 3'd2;
   localparam logic [2:0] OP_CUBE = 3'd3;
   localparam logic [2:0] OP_BACK = 3'd4;
   localparam logic [2:0] OP_BNC  = 3'd5;

   localparam logic [1:0] K_ZERO = 2'd0;
   localparam logic [1:0] K_ONE  = 2'd1;
   localparam logic [1:0] K_TWO  = 2'd2;

   localparam logic [2:0] REG_START = 3'd0;
   localparam logic [2:0] REG_END   = 3'd1;
   localparam logic [2:0] REG_COUNT = 3'd2;
   localparam logic [2:0] REG_MODE  = 3'd3;
   localparam logic [2:0] REG_OVER  = 3'd4;

   typedef struct packed {
      logic err;
      logic last;
   } tag_type;

   typedef struct packed {
      logic n1;
      logic hf;
      logic n2;
   } post_type;

   typedef struct packed {
      logic [CW:0]   rem;
      logic [TW-1:0] quo;
      logic [CW-1:0] m;
      logic [TW-1:0] nlow;
      tag_type       tag;
   } div_type;

   // round p / 2^k to nearest, ties away from zero
   function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] p,
                                                  input logic [4:0] k);
      logic signed [63:0] bias;
      bias = (64'sd1 <<< (k - 5'd1)) - $signed({63'd0, p[63]});
      return (p + bias) >>> k;
   endfunction

endpackage
`default_nettype wire

[rtl/easing_curve_sampler_unit.sv]
// channel  | dir | beat contents
// req      | in  | tdata[11:0] sample_index
// rsp      | out | tdata[31:0] sample_value, tlast is_last, tuser[0] index_error
// csr      | in  | apb registers start, end, count, mode, overshoot at 0x0..0x10
//
// one sample per cycle unless the output stalls; an input stage, 9 stages of a
// 2-bit-per-stage restoring divider for t, 10 stages of curve and scaling math
// reset clears the stage valids and loads the register defaults
// each stage holds only while the one after it is full and held, so bubbles
// close up under an output stall
`timescale 1ns / 1ps
`default_nettype none
module easing_curve_sampler_unit #(
   parameter int MAX_SAMPLES = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [11:0] sample_index
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] sample_value
   output logic             rsp_tlast,
   output logic [0:0]       rsp_tuser,   // [0] index_error
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import ecs_pkg::*;

   localparam int DIV_BPS = 2;
   localparam int DIV_ST  = (TW + DIV_BPS - 1) / DIV_BPS;
   localparam int NST     = DIV_ST + 11;
   localparam int ST_C1   = DIV_ST + 1;
   localparam int ST_C2   = DIV_ST + 2;
   localparam int ST_C3   = DIV_ST + 3;
   localparam int ST_C4   = DIV_ST + 4;
   localparam int ST_C5   = DIV_ST + 5;
   localparam int ST_C6   = DIV_ST + 6;
   localparam int ST_C7   = DIV_ST + 7;
   localparam int ST_C8   = DIV_ST + 8;
   localparam int ST_C9   = DIV_ST + 9;
   localparam int ST_OUT  = DIV_ST + 10;

   // configuration registers
   logic [31:0]   start_ff;
   logic [31:0]   end_ff;
   logic [CW-1:0] count_ff;
   logic [3:0]    mode_ff;
   logic [18:0]   over_ff;
   logic          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 32'd0;
         end_ff   <= 32'd65536;
         count_ff <= 13'd2;
         mode_ff  <= 4'd0;
         over_ff  <= 19'd111514;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            REG_START: start_ff <= csr_pwdata;
            REG_END:   end_ff   <= csr_pwdata;
            REG_COUNT: count_ff <= csr_pwdata[CW-1:0];
            REG_MODE:  mode_ff  <= csr_pwdata[3:0];
            REG_OVER:  over_ff  <= csr_pwdata[18:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_START: csr_prdata = start_ff;
         REG_END:   csr_prdata = end_ff;
         REG_COUNT: csr_prdata = {19'd0, count_ff};
         REG_MODE:  csr_prdata = {28'd0, mode_ff};
         REG_OVER:  csr_prdata = {13'd0, over_ff};
         default:   csr_prdata = 32'd0;
      endcase
   end

   // stage valids and ready chain
   logic [NST-1:0] v_ff;
   logic [NST:0]   rdy;

   always_comb begin
      rdy[NST] = rsp_tready;
      for (int k = NST - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign req_tready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NST; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // input stage and divider t = (i*2^F + m/2) / m
   logic [IW-1:0] idx;
   logic [CW-1:0] n_cl;
   logic [CW-1:0] m_in;
   tag_type       tag_in;
   div_type       div_ff [0:DIV_ST];
   div_type       div_nx [0:DIV_ST];

   assign idx  = req_tdata[IW-1:0];
   assign n_cl = (17'(count_ff) > 17'(MAX_SAMPLES)) ? CW'(MAX_SAMPLES) : count_ff;
   assign m_in = n_cl - 13'd1;
   assign tag_in.err  = (n_cl < 13'd2) || ({1'b0, idx} >= n_cl);
   assign tag_in.last = ({1'b0, idx} == m_in) && !tag_in.err;

   always_comb begin
      logic [CW:0]   r;
      logic [TW-1:0] q;
      int            j;
      int            bi;
      div_nx[0].rem  = {3'd0, idx[IW-1:1]};
      div_nx[0].quo  = '0;
      div_nx[0].m    = m_in;
      div_nx[0].nlow = {idx[0], 4'd0, m_in[CW-1:1]};
      div_nx[0].tag  = tag_in;
      for (int g = 1; g <= DIV_ST; g++) begin
         r = div_ff[g-1].rem;
         q = div_ff[g-1].quo;
         for (int b = 0; b < DIV_BPS; b++) begin
            j  = (g - 1) * DIV_BPS + b;
            bi = (j < TW) ? (TW - 1 - j) : 0;
            if (j < TW) begin
               r = {r[CW-1:0], div_ff[g-1].nlow[bi]};
               if (r >= {1'b0, div_ff[g-1].m}) begin
                  r = r - {1'b0, div_ff[g-1].m};
                  q = {q[TW-2:0], 1'b1};
               end else begin
                  q = {q[TW-2:0], 1'b0};
               end
            end
         end
         div_nx[g]     = div_ff[g-1];
         div_nx[g].rem = r;
         div_nx[g].quo = q;
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g <= DIV_ST; g++) begin
         if (rdy[g]) begin
            div_ff[g] <= div_nx[g];
         end
      end
   end

   // c1: curve operand and post op selection
   logic signed [VW-1:0] tv, uv, c1_x_in;
   logic                 lower;
   logic [2:0]           c1_op_in;
   post_type             c1_post_in;
   logic [1:0]           c1_kc_in;

   logic signed [VW-1:0] c1_x_ff;
   logic [2:0]           c1_op_ff;
   post_type             c1_post_ff;
   logic [1:0]           c1_kc_ff;
   tag_type              c1_tag_ff;

   assign tv    = $signed({{(VW - TW){1'b0}}, div_ff[DIV_ST].quo});
   assign uv    = tv <<< 1;
   assign lower = uv < ONE_V;

   always_comb begin
      c1_x_in    = tv;
      c1_op_in   = OP_LIN;
      c1_post_in = '0;
      c1_kc_in   = K_ZERO;
      case (mode_ff)
         MODE_QUAD_IN: c1_op_in = OP_SQ;
         MODE_QUAD_OUT: c1_op_in = OP_QO;
         MODE_QUAD_INOUT: begin
            c1_post_in.hf = 1'b1;
            if (lower) begin
               c1_x_in  = uv;
               c1_op_in = OP_SQ;
            end else begin
               c1_x_in  = uv - ONE_V;
               c1_op_in = OP_QO;
               c1_kc_in = K_ONE;
            end
         end
         MODE_CUBE_IN: c1_op_in = OP_CUBE;
         MODE_CUBE_OUT: begin
            c1_x_in  = tv - ONE_V;
            c1_op_in = OP_CUBE;
            c1_kc_in = K_ONE;
         end
         MODE_CUBE_INOUT: begin
            c1_op_in      = OP_CUBE;
            c1_post_in.hf = 1'b1;
            if (lower) begin
               c1_x_in = uv;
            end else begin
               c1_x_in  = uv - TWO_V;
               c1_kc_in = K_TWO;
            end
         end
         MODE_BACK_IN: c1_op_in = OP_BACK;
         MODE_BACK_OUT: begin
            c1_x_in       = ONE_V - tv;
            c1_op_in      = OP_BACK;
            c1_post_in.n2 = 1'b1;
         end
         MODE_BACK_INOUT: begin
            c1_op_in      = OP_BACK;
            c1_post_in.hf = 1'b1;
            if (lower) begin
               c1_x_in = uv;
            end else begin
               c1_x_in       = TWO_V - uv;
               c1_post_in.n2 = 1'b1;
            end
         end
         MODE_BNC_IN: begin
            c1_x_in       = ONE_V - tv;
            c1_op_in      = OP_BNC;
            c1_post_in.n1 = 1'b1;
         end
         MODE_BNC_OUT: c1_op_in = OP_BNC;
         MODE_BNC_INOUT: begin
            c1_op_in      = OP_BNC;
            c1_post_in.n1 = 1'b1;
            c1_post_in.hf = 1'b1;
            if (lower) begin
               c1_x_in = ONE_V - uv;
            end else begin
               c1_x_in       = uv - ONE_V;
               c1_post_in.n2 = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_C1]) begin
         c1_x_ff    <= c1_x_in;
         c1_op_ff   <= c1_op_in;
         c1_post_ff <= c1_post_in;
         c1_kc_ff   <= c1_kc_in;
         c1_tag_ff  <= div_ff[DIV_ST].tag;
      end
   end

   // c2: multiplier operands, bounce piece
   logic signed [VW-1:0] s_v, x11, x22, bw, bc;
   logic                 b_last;
   logic signed [VW-1:0] a1_in, b1_in, kval_in;
   logic [4:0]           k1_in;

   logic signed [VW-1:0] c2_a1_ff, c2_b1_ff, c2_a2_ff, c2_b2_ff, c2_k_ff, c2_x_ff;
   logic [4:0]           c2_sh_ff;
   logic                 c2_use3_ff, c2_back_ff;
   post_type             c2_post_ff;
   tag_type              c2_tag_ff;

   assign s_v = $signed({{(VW - 19){1'b0}}, over_ff});
   assign x11 = (c1_x_ff <<< 3) + (c1_x_ff <<< 1) + c1_x_ff;
   assign x22 = x11 <<< 1;

   always_comb begin
      b_last = 1'b0;
      if (c1_x_ff < BT1_V) begin
         bw = x11;
         bc = '0;
      end else if (c1_x_ff < BT2_V) begin
         bw = x11 - SIX_V;
         bc = BC1_V;
      end else if (c1_x_ff < BT3_V) begin
         bw = x11 - NINE_V;
         bc = BC2_V;
      end else begin
         bw     = x22 - TW1_V;
         bc     = BC3_V;
         b_last = 1'b1;
      end
   end

   always_comb begin
      a1_in = c1_x_ff;
      b1_in = ONE_V;
      k1_in = SH_F;
      case (c1_op_ff) inside
         OP_SQ, OP_CUBE, OP_BACK: b1_in = c1_x_ff;
         OP_QO: b1_in = TWO_V - c1_x_ff;
         OP_BNC: begin
            a1_in = bw;
            b1_in = bw;
            k1_in = b_last ? SH_BNC3 : SH_BNC;
         end
         default: ;
      endcase
      if (c1_op_ff == OP_BNC) begin
         kval_in = c1_post_ff.n1 ? (ONE_V - bc) : bc;
      end else begin
         case (c1_kc_ff)
            K_ONE:   kval_in = ONE_V;
            K_TWO:   kval_in = TWO_V;
            default: kval_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_C2]) begin
         c2_a1_ff   <= a1_in;
         c2_b1_ff   <= b1_in;
         c2_a2_ff   <= c1_x_ff;
         c2_b2_ff   <= s_v + ONE_V;
         c2_sh_ff   <= k1_in;
         c2_k_ff    <= kval_in;
         c2_x_ff    <= c1_x_ff;
         c2_use3_ff <= (c1_op_ff == OP_CUBE) || (c1_op_ff == OP_BACK);
         c2_back_ff <= (c1_op_ff == OP_BACK);
         c2_post_ff <= c1_post_ff;
         c2_tag_ff  <= c1_tag_ff;
      end
   end

   // c3: first products
   logic signed [PW-1:0] c3_p1_ff, c3_p2_ff;
   logic signed [VW-1:0] c3_k_ff, c3_x_ff;
   logic [4:0]           c3_sh_ff;
   logic                 c3_use3_ff, c3_back_ff;
   post_type             c3_post_ff;
   tag_type              c3_tag_ff;

   always_ff @(posedge clock) begin
      if (rdy[ST_C3]) begin
         c3_p1_ff   <= c2_a1_ff * c2_b1_ff;
         c3_p2_ff   <= c2_a2_ff * c2_b2_ff;
         c3_k_ff    <= c2_k_ff;
         c3_x_ff    <= c2_x_ff;
         c3_sh_ff   <= c2_sh_ff;
         c3_use3_ff <= c2_use3_ff;
         c3_back_ff <= c2_back_ff;
         c3_post_ff <= c2_post_ff;
         c3_tag_ff  <= c2_tag_ff;
      end
   end

   // c4: round, form third operand
   logic signed [VW-1:0] q1_v, q2_v;
   logic signed [VW-1:0] c4_q1_ff, c4_e_ff, c4_k_ff;
   logic                 c4_use3_ff;
   post_type             c4_post_ff;
   tag_type              c4_tag_ff;

   assign q1_v = VW'(rnd_shr(64'(c3_p1_ff), c3_sh_ff));
   assign q2_v = VW'(rnd_shr(64'(c3_p2_ff), SH_F));

   always_ff @(posedge clock) begin
      if (rdy[ST_C4]) begin
         c4_q1_ff   <= q1_v;
         c4_e_ff    <= c3_back_ff ? (q2_v - s_v) : c3_x_ff;
         c4_k_ff    <= c3_k_ff;
         c4_use3_ff <= c3_use3_ff;
         c4_post_ff <= c3_post_ff;
         c4_tag_ff  <= c3_tag_ff;
      end
   end

   // c5: third product
   logic signed [PW-1:0] c5_p3_ff;
   logic signed [VW-1:0] c5_q1_ff, c5_k_ff;
   logic                 c5_use3_ff;
   post_type             c5_post_ff;
   tag_type              c5_tag_ff;

   always_ff @(posedge clock) begin
      if (rdy[ST_C5]) begin
         c5_p3_ff   <= c4_q1_ff * c4_e_ff;
         c5_q1_ff   <= c4_q1_ff;
         c5_k_ff    <= c4_k_ff;
         c5_use3_ff <= c4_use3_ff;
         c5_post_ff <= c4_post_ff;
         c5_tag_ff  <= c4_tag_ff;
      end
   end

   // c6: base curve value
   logic signed [VW-1:0] c6_q_ff, c6_k_ff;
   post_type             c6_post_ff;
   tag_type              c6_tag_ff;

   always_ff @(posedge clock) begin
      if (rdy[ST_C6]) begin
         c6_q_ff    <= c5_use3_ff ? VW'(rnd_shr(64'(c5_p3_ff), SH_F)) : c5_q1_ff;
         c6_k_ff    <= c5_k_ff;
         c6_post_ff <= c5_post_ff;
         c6_tag_ff  <= c5_tag_ff;
      end
   end

   // c7: offset or reflect
   logic signed [VW-1:0] c7_g_ff;
   post_type             c7_post_ff;
   tag_type              c7_tag_ff;

   always_ff @(posedge clock) begin
      if (rdy[ST_C7]) begin
         c7_g_ff    <= c6_post_ff.n1 ? (c6_k_ff - c6_q_ff) : (c6_q_ff + c6_k_ff);
         c7_post_ff <= c6_post_ff;
         c7_tag_ff  <= c6_tag_ff;
      end
   end

   // c8: halve and mirror
   logic signed [VW-1:0] h_v;
   logic signed [VW-1:0] c8_f_ff;
   tag_type              c8_tag_ff;

   assign h_v = c7_post_ff.hf ? VW'(rnd_shr(64'(c7_g_ff), SH_HALF)) : c7_g_ff;

   always_ff @(posedge clock) begin
      if (rdy[ST_C8]) begin
         c8_f_ff   <= c7_post_ff.n2 ? (ONE_V - h_v) : h_v;
         c8_tag_ff <= c7_tag_ff;
      end
   end

   // c9: scale by span
   logic signed [32:0]   dd;
   logic signed [VW+32:0] c9_p_ff;
   tag_type              c9_tag_ff;

   assign dd = $signed({end_ff[31], end_ff}) - $signed({start_ff[31], start_ff});

   always_ff @(posedge clock) begin
      if (rdy[ST_C9]) begin
         c9_p_ff   <= c8_f_ff * dd;
         c9_tag_ff <= c8_tag_ff;
      end
   end

   // output stage: offset, saturate
   logic signed [63:0] sum_v;
   logic [31:0]        sat_v;
   logic [31:0]        out_val_ff;
   tag_type            out_tag_ff;

   assign sum_v = $signed({{32{start_ff[31]}}, start_ff}) + rnd_shr(64'(c9_p_ff), SH_F);

   always_comb begin
      if (sum_v > 64'sd2147483647) begin
         sat_v = 32'h7fff_ffff;
      end else if (sum_v < -64'sd2147483648) begin
         sat_v = 32'h8000_0000;
      end else begin
         sat_v = sum_v[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_OUT]) begin
         out_val_ff <= c9_tag_ff.err ? 32'd0 : sat_v;
         out_tag_ff <= c9_tag_ff;
      end
   end

   assign rsp_tvalid = v_ff[ST_OUT];
   assign rsp_tdata  = out_val_ff;
   assign rsp_tlast  = out_tag_ff.last;
   assign rsp_tuser  = out_tag_ff.err;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 32'd0 && !rsp_tlast)
      else $error("index error beat with nonzero value or last");

   a_t_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[DIV_ST] && !div_ff[DIV_ST].tag.err |-> div_ff[DIV_ST].quo <= TW'(ONE_V))
      else $error("curve position above one");

   a_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v_ff[0])
      else $error("accepted beat not captured");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !v_ff[ST_OUT-1] |=> !rsp_tvalid)
      else $error("result beat repeated");

endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
   import ecs_pkg::*;

   localparam int N_RANDOM = 1750;
   localparam longint CYCLE_LIMIT = 400000;
   localparam longint ONE_Q = 64'sd1 << 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   easing_curve_sampler_unit dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   typedef struct {
      logic [31:0] value;
      logic        last;
      logic        err;
   } sample_type;

   sample_type  pending_samples[$];
   int          mismatch_count = 0;
   longint      cycle_count = 0;
   bit          hold_off = 1'b0;
   int          hold_cycles = 0;

   // shadow configuration
   logic [31:0] cfg_start = 32'd0;
   logic [31:0] cfg_end = 32'd65536;
   logic [12:0] cfg_count = 13'd2;
   logic [3:0]  cfg_mode = 4'd0;
   logic [18:0] cfg_over = 19'd111514;

   function automatic longint round_shift(longint p, int k);
      longint mag, r;
      mag = p < 0 ? -p : p;
      r = (mag + (64'sd1 << (k - 1))) >>> k;
      return p < 0 ? -r : r;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return round_shift(a * b, 16);
   endfunction

   function automatic longint back_in_q(longint t, longint s);
      return qmul(qmul(t, t), qmul(t, s + ONE_Q) - s);
   endfunction

   function automatic longint bounce_out_q(longint t);
      longint t11, x;
      t11 = 11 * t;
      if (t11 < 4 * ONE_Q) return round_shift(t11 * t11, 20);
      if (t11 < 8 * ONE_Q) begin
         x = t11 - 6 * ONE_Q;
         return round_shift(x * x, 20) + 3 * ONE_Q / 4;
      end
      if (t11 < 10 * ONE_Q) begin
         x = t11 - 9 * ONE_Q;
         return round_shift(x * x, 20) + 15 * ONE_Q / 16;
      end
      x = 22 * t - 21 * ONE_Q;
      return round_shift(x * x, 22) + 63 * ONE_Q / 64;
   endfunction

   function automatic longint bounce_in_q(longint t);
      return ONE_Q - bounce_out_q(ONE_Q - t);
   endfunction

   function automatic longint ease(logic [3:0] mode, longint t, longint s);
      longint u, v;
      u = 2 * t;
      case (mode)
         MODE_QUAD_IN: return qmul(t, t);
         MODE_QUAD_OUT: return qmul(t, 2 * ONE_Q - t);
         MODE_QUAD_INOUT: begin
            if (u < ONE_Q) return round_shift(qmul(u, u), 1);
            v = u - ONE_Q;
            return round_shift(ONE_Q + qmul(v, 2 * ONE_Q - v), 1);
         end
         MODE_CUBE_IN: return qmul(qmul(t, t), t);
         MODE_CUBE_OUT: begin
            v = t - ONE_Q;
            return qmul(qmul(v, v), v) + ONE_Q;
         end
         MODE_CUBE_INOUT: begin
            if (u < ONE_Q) return round_shift(qmul(qmul(u, u), u), 1);
            v = u - 2 * ONE_Q;
            return round_shift(qmul(qmul(v, v), v) + 2 * ONE_Q, 1);
         end
         MODE_BACK_IN: return back_in_q(t, s);
         MODE_BACK_OUT: return ONE_Q - back_in_q(ONE_Q - t, s);
         MODE_BACK_INOUT: begin
            if (u < ONE_Q) return round_shift(back_in_q(u, s), 1);
            return ONE_Q - round_shift(back_in_q(2 * ONE_Q - u, s), 1);
         end
         MODE_BNC_IN: return bounce_in_q(t);
         MODE_BNC_OUT: return bounce_out_q(t);
         MODE_BNC_INOUT: begin
            if (u < ONE_Q) return round_shift(bounce_in_q(u), 1);
            return ONE_Q - round_shift(bounce_in_q(2 * ONE_Q - u), 1);
         end
         default: return t;
      endcase
   endfunction

   function automatic sample_type predict_sample(logic [11:0] idx);
      sample_type r;
      longint n, m, t, f, st, d, val;
      n = cfg_count;
      if (n > 4096) n = 4096;
      r.value = '0;
      r.last = 1'b0;
      r.err = 1'b1;
      if (n < 2 || idx >= n) return r;
      m = n - 1;
      t = ((longint'(idx) << 16) + m / 2) / m;
      f = ease(cfg_mode, t, longint'(cfg_over));
      st = longint'($signed(cfg_start));
      d = longint'($signed(cfg_end)) - st;
      val = st + round_shift(f * d, 16);
      if (val > 64'sd2147483647) val = 64'sd2147483647;
      if (val < -64'sd2147483648) val = -64'sd2147483648;
      r.value = val[31:0];
      r.last = (idx == m);
      r.err = 1'b0;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout");
         $display("== FAIL ==");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      sample_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_samples.size() == 0) begin
            report_mismatch("unexpected beat", rsp_tdata, 32'd0);
         end else begin
            want = pending_samples.pop_front();
            if (rsp_tdata !== want.value) report_mismatch("sample_value", rsp_tdata, want.value);
            if (rsp_tlast !== want.last) report_mismatch("is_last", rsp_tlast, want.last);
            if (rsp_tuser[0] !== want.err) report_mismatch("index_error", rsp_tuser, want.err);
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (hold_off) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         case ($urandom_range(0, 19))
            0, 1, 2: hold_cycles <= $urandom_range(1, 3);
            3: hold_cycles <= $urandom_range(10, 40);
            default: ;
         endcase
         rsp_tready <= ($urandom_range(0, 9) != 0);
      end
   end

   task automatic send_index(logic [11:0] idx, bit may_idle = 1'b1);
      int gap;
      if (may_idle) begin
         gap = 0;
         case ($urandom_range(0, 19))
            0, 1, 2: gap = $urandom_range(1, 3);
            3: gap = $urandom_range(8, 30);
            default: ;
         endcase
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_samples.push_back(predict_sample(idx));
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
   endtask

   task automatic drain();
      end_burst();
      @(posedge clock);
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] reg_sel, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_sel, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (reg_sel)
         REG_START: cfg_start = value;
         REG_END: cfg_end = value;
         REG_COUNT: cfg_count = value[12:0];
         REG_MODE: cfg_mode = value[3:0];
         REG_OVER: cfg_over = value[18:0];
         default: ;
      endcase
   endtask

   task automatic set_curve(logic [31:0] s, logic [31:0] e, logic [12:0] n,
                            logic [3:0] mode, logic [18:0] over);
      write_csr(REG_START, s);
      write_csr(REG_END, e);
      write_csr(REG_COUNT, {19'd0, n});
      write_csr(REG_MODE, {28'd0, mode});
      write_csr(REG_OVER, {13'd0, over});
   endtask

   task automatic test_reset_defaults();
      send_index(12'd0);
      send_index(12'd1);
      send_index(12'd2);
      send_index(12'hFFF);
      drain();
   endtask

   task automatic test_directed_modes();
      for (int mode = 0; mode < 16; mode++) begin
         set_curve(32'h8000_0000, 32'h7FFF_FFFF, 13'd5, mode[3:0], 19'h7FFFF);
         send_index(12'd0);
         send_index(12'd4);
         drain();
      end
      set_curve(32'd0, 32'd65536, 13'd1, 4'd0, 19'd111514);
      send_index(12'd0);
      drain();
      set_curve(32'd0, 32'd65536, 13'd0, 4'd0, 19'd0);
      send_index(12'd0);
      drain();
      set_curve(32'h7FFF_FFFF, 32'h8000_0000, 13'h1FFF, MODE_BACK_INOUT, 19'd0);
      send_index(12'd0);
      send_index(12'd2048);
      send_index(12'd4095);
      drain();
   endtask

   task automatic test_random_curves();
      int n_sent, burst;
      logic [12:0] n;
      logic [11:0] idx;
      n_sent = 0;
      while (n_sent < N_RANDOM) begin
         case ($urandom_range(0, 5))
            0: n = 13'($urandom_range(2, 8));
            1: n = 13'($urandom_range(0, 8191));
            2: n = 13'd4096;
            default: n = 13'($urandom_range(2, 300));
         endcase
         set_curve($urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 200000)),
                   $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 200000)),
                   n, 4'($urandom_range(0, 15)), 19'($urandom));
         burst = $urandom_range(20, 120);
         for (int k = 0; k < burst; k++) begin
            if ($urandom_range(0, 9) == 0) idx = 12'($urandom);
            else if (n > 1) idx = 12'($urandom_range(0, (n > 4096 ? 4096 : n) - 1));
            else idx = 12'($urandom);
            send_index(idx);
         end
         n_sent += burst;
         drain();
      end
   endtask

   task automatic test_output_backpressure();
      set_curve(32'hFFFF_0000, 32'd300000, 13'd64, MODE_BNC_INOUT, 19'd111514);
      fork
         begin
            hold_off = 1'b1;
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int k = 0; k < 60; k++) send_index(12'(k), 1'b0);
      join
      drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_modes();
      test_output_backpressure();
      test_random_curves();
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
